@@ hdl/mld_pkg.sv @@
// ----------------------------------------------------------------------------
// Morse light decoder package
// Shared widths, result codes, status structs and the Morse code table.
// ----------------------------------------------------------------------------
package mld_pkg;

    localparam int MAX_ELEMENTS = 5;
    localparam int SYM_LEN_W    = $clog2(MAX_ELEMENTS + 2);
    localparam int THRESH_W     = 10;
    localparam int DOT_W        = 16;
    localparam int TIME_W       = 32;
    localparam int CHAR_W       = 7;

    localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(512);
    localparam logic [DOT_W-1:0]    DOT_RESET    = DOT_W'(100);
    localparam logic [CHAR_W-1:0]   SPACE_CHAR   = 7'h20;

    typedef enum logic [1:0] {
        KIND_CHAR  = 2'd0,
        KIND_SPACE = 2'd1,
        KIND_END   = 2'd2
    } t_kind;

    typedef enum logic {
        CFG_THRESHOLD = 1'b0,
        CFG_DOT_LEN   = 1'b1
    } t_cfg_index;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_ACK    = 1'b1
    } t_op;

    typedef struct packed {
        logic is_dot;
        logic is_dash;
        logic decode_gap;
        logic space_gap;
    } t_timing;

    typedef struct packed {
        logic              hit;
        logic [CHAR_W-1:0] ch;
    } t_decode;

    typedef struct packed {
        logic [3:0]        len;
        logic [7:0]        bits;
        logic [CHAR_W-1:0] ch;
    } t_code_entry;

    localparam int CODE_COUNT = 36;

    // Dash is a one, elements first-received in the MSB. The end marker is
    // deliberately absent: it decodes as a miss, the same as unknown symbols.
    localparam t_code_entry CODE_TABLE [CODE_COUNT] = '{
        '{4'd2, 8'b00000001, 7'h61}, '{4'd4, 8'b00001000, 7'h62},
        '{4'd4, 8'b00001010, 7'h63}, '{4'd3, 8'b00000100, 7'h64},
        '{4'd1, 8'b00000000, 7'h65}, '{4'd4, 8'b00000010, 7'h66},
        '{4'd3, 8'b00000110, 7'h67}, '{4'd4, 8'b00000000, 7'h68},
        '{4'd2, 8'b00000000, 7'h69}, '{4'd4, 8'b00000111, 7'h6a},
        '{4'd3, 8'b00000101, 7'h6b}, '{4'd4, 8'b00000100, 7'h6c},
        '{4'd2, 8'b00000011, 7'h6d}, '{4'd2, 8'b00000010, 7'h6e},
        '{4'd3, 8'b00000111, 7'h6f}, '{4'd4, 8'b00000110, 7'h70},
        '{4'd4, 8'b00001101, 7'h71}, '{4'd3, 8'b00000010, 7'h72},
        '{4'd3, 8'b00000000, 7'h73}, '{4'd1, 8'b00000001, 7'h74},
        '{4'd3, 8'b00000001, 7'h75}, '{4'd4, 8'b00000001, 7'h76},
        '{4'd3, 8'b00000011, 7'h77}, '{4'd4, 8'b00001001, 7'h78},
        '{4'd4, 8'b00001011, 7'h79}, '{4'd4, 8'b00001100, 7'h7a},
        '{4'd5, 8'b00011111, 7'h30}, '{4'd5, 8'b00001111, 7'h31},
        '{4'd5, 8'b00000111, 7'h32}, '{4'd5, 8'b00000011, 7'h33},
        '{4'd5, 8'b00000001, 7'h34}, '{4'd5, 8'b00000000, 7'h35},
        '{4'd5, 8'b00010000, 7'h36}, '{4'd5, 8'b00011000, 7'h37},
        '{4'd5, 8'b00011100, 7'h38}, '{4'd5, 8'b00011110, 7'h39}
    };

endpackage

@@ hdl/mld_timing.sv @@
// ----------------------------------------------------------------------------
// Morse light decoder pulse and gap timing
// Classifies the pulse length and tests the off-time against the decode and
// word-space limits, all scaled from the dot length.
// ----------------------------------------------------------------------------
module mld_timing
    import mld_pkg::*;
(
    input  logic [TIME_W-1:0] i_now_ms,
    input  logic [TIME_W-1:0] i_pulse_start,
    input  logic [TIME_W-1:0] i_last_edge,
    input  logic [DOT_W-1:0]  i_dot_len,
    output t_timing           o_timing
);

    logic [TIME_W-1:0]  dur;
    logic [TIME_W-1:0]  gap;
    logic [DOT_W+1:0]   dot3;
    logic [DOT_W+3:0]   dot9;
    logic [TIME_W+2:0]  gap5;
    logic [TIME_W:0]    gap2;

    always_comb begin
        dur  = i_now_ms - i_pulse_start;
        gap  = i_now_ms - i_last_edge;
        dot3 = {1'b0, i_dot_len, 1'b0} + {2'b00, i_dot_len};
        dot9 = {1'b0, i_dot_len, 3'b000} + {4'b0000, i_dot_len};
        gap5 = {1'b0, gap, 2'b00} + {3'b000, gap};
        gap2 = {gap, 1'b0};

        // The 1.8 and 4.5 dot limits are tested exactly as 5*gap >= 9*dot
        // and 2*gap >= 9*dot.
        o_timing.is_dot     = dur <= TIME_W'(i_dot_len);
        o_timing.is_dash    = dur <= TIME_W'(dot3);
        o_timing.decode_gap = gap5 >= (TIME_W+3)'(dot9);
        o_timing.space_gap  = gap2 >= (TIME_W+1)'(dot9);
    end

endmodule

@@ hdl/mld_decode.sv @@
// ----------------------------------------------------------------------------
// Morse light decoder symbol lookup
// Matches the pending symbol against the code table and returns its character.
// ----------------------------------------------------------------------------
module mld_decode
    import mld_pkg::*;
(
    input  logic [SYM_LEN_W-1:0]    i_sym_len,
    input  logic [MAX_ELEMENTS-1:0] i_sym_bits,
    output t_decode                 o_decode
);

    logic [CODE_COUNT-1:0] match;

    always_comb begin
        for (int i = 0; i < CODE_COUNT; i++) begin
            match[i] = (CODE_TABLE[i].len == 4'(i_sym_len))
                    && (CODE_TABLE[i].bits == 8'(i_sym_bits));
        end
    end

    // At most one entry matches, so an OR over the gated characters selects it.
    always_comb begin
        o_decode.hit = |match;
        o_decode.ch  = '0;
        for (int i = 0; i < CODE_COUNT; i++) begin
            o_decode.ch = o_decode.ch | (CODE_TABLE[i].ch & {CHAR_W{match[i]}});
        end
    end

endmodule

@@ hdl/morse_light_decoder_core.sv @@
// ----------------------------------------------------------------------------
// Morse light decoder core
// Turns timestamped light samples into a stream of decoded Morse characters.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries, when unstalled, one request
//   per cycle: a sensor sample with its millisecond timestamp (i_op = 0), or the
//   host acknowledge that the current message has been taken (i_op = 1).
//   Output channel (o_out_valid / i_out_stall) carries at most one result
//   per request: a character, a word space or an end of message.
//   A request is registered on acceptance and fully processed from the input
//   register; its result enters the result register when the request advances.
//   One request is taken every cycle unless a result stalls; the state update,
//   timing compares and table lookup sit between input and result register.
//   While the receiver stalls, the result register holds its value and the
//   input register still drains into it as soon as the result is taken; with
//   both registers full, o_in_stall follows i_out_stall.
//   Reset (i_rst_n low, synchronous) empties both registers, clears the
//   decoder state and restores threshold 512 and dot length 100 ms.
//   Configuration writes through i_cfg_we take effect at once; the user is to
//   make them only while no request is in flight, unchecked by the block.
// ----------------------------------------------------------------------------
module morse_light_decoder_core
    import mld_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [DOT_W-1:0]    i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_op,
    input  logic [THRESH_W-1:0] i_sample,
    input  logic [TIME_W-1:0]   i_now_ms,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [1:0]          o_kind,
    output logic [CHAR_W-1:0]   o_char_code
);

    // Configuration
    logic [THRESH_W-1:0] r_threshold;
    logic [DOT_W-1:0]    r_dot_len;

    // Input register
    logic                r_in_valid;
    logic                r_op;
    logic [THRESH_W-1:0] r_sample;
    logic [TIME_W-1:0]   r_now;

    // Decoder state
    logic                    r_receiving,  n_receiving;
    logic [TIME_W-1:0]       r_pulse_start, n_pulse_start;
    logic [TIME_W-1:0]       r_last_edge,  n_last_edge;
    logic [MAX_ELEMENTS-1:0] r_sym_bits,   n_sym_bits;
    logic [SYM_LEN_W-1:0]    r_sym_len,    n_sym_len;
    logic                    r_space_done, n_space_done;
    logic                    r_msg_nonempty, n_msg_nonempty;

    // Result register
    logic              r_out_valid;
    t_kind             r_kind,  n_kind;
    logic [CHAR_W-1:0] r_char,  n_char;
    logic              n_emit;

    logic    advance;
    t_timing timing;
    t_decode dec;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;

    mld_timing u_timing (
        .i_now_ms      (r_now),
        .i_pulse_start (r_pulse_start),
        .i_last_edge   (r_last_edge),
        .i_dot_len     (r_dot_len),
        .o_timing      (timing)
    );

    mld_decode u_decode (
        .i_sym_len  (r_sym_len),
        .i_sym_bits (r_sym_bits),
        .o_decode   (dec)
    );

    always_comb begin
        n_receiving    = r_receiving;
        n_pulse_start  = r_pulse_start;
        n_last_edge    = r_last_edge;
        n_sym_bits     = r_sym_bits;
        n_sym_len      = r_sym_len;
        n_space_done   = r_space_done;
        n_msg_nonempty = r_msg_nonempty;
        n_emit         = 1'b0;
        n_kind         = KIND_CHAR;
        n_char         = '0;

        if (r_op == OP_ACK) begin
            n_msg_nonempty = 1'b0;
        end else if (r_sample > r_threshold) begin
            if (!r_receiving) begin
                n_receiving   = 1'b1;
                n_space_done  = 1'b0;
                n_pulse_start = r_now;
            end
        end else if (r_receiving) begin
            n_receiving = 1'b0;
            n_last_edge = r_now;
            // Pulses longer than three dots add nothing.
            if (timing.is_dot || timing.is_dash) begin
                if (r_sym_len < SYM_LEN_W'(MAX_ELEMENTS)) begin
                    n_sym_bits = {r_sym_bits[MAX_ELEMENTS-2:0], !timing.is_dot};
                    n_sym_len  = r_sym_len + SYM_LEN_W'(1);
                end else begin
                    // Overlong symbol saturates and later misses the table.
                    n_sym_len = SYM_LEN_W'(MAX_ELEMENTS + 1);
                end
            end
        end else if (timing.decode_gap && (r_sym_len != '0)) begin
            n_sym_bits = '0;
            n_sym_len  = '0;
            if (dec.hit) begin
                n_msg_nonempty = 1'b1;
                n_emit         = 1'b1;
                n_kind         = KIND_CHAR;
                n_char         = dec.ch;
            end else if (r_msg_nonempty) begin
                n_emit = 1'b1;
                n_kind = KIND_END;
            end
        end else if (timing.space_gap && r_msg_nonempty && !r_space_done) begin
            n_space_done = 1'b1;
            n_last_edge  = r_now;
            n_emit       = 1'b1;
            n_kind       = KIND_SPACE;
            n_char       = SPACE_CHAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESH_RESET;
            r_dot_len   <= DOT_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_THRESHOLD: r_threshold <= i_cfg_data[THRESH_W-1:0];
                CFG_DOT_LEN:   r_dot_len   <= i_cfg_data;
                default:       r_dot_len   <= r_dot_len;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_op     <= i_op;
            r_sample <= i_sample;
            r_now    <= i_now_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_receiving    <= 1'b0;
            r_pulse_start  <= '0;
            r_last_edge    <= '0;
            r_sym_bits     <= '0;
            r_sym_len      <= '0;
            r_space_done   <= 1'b0;
            r_msg_nonempty <= 1'b0;
        end else if (advance) begin
            r_receiving    <= n_receiving;
            r_pulse_start  <= n_pulse_start;
            r_last_edge    <= n_last_edge;
            r_sym_bits     <= n_sym_bits;
            r_sym_len      <= n_sym_len;
            r_space_done   <= n_space_done;
            r_msg_nonempty <= n_msg_nonempty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && n_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && n_emit) begin
            r_kind <= n_kind;
            r_char <= n_char;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_char_code = r_char;

endmodule

@@ hdl/mld_checker.sv @@
// ----------------------------------------------------------------------------
// Morse light decoder port checker
// Watches the top-level ports for handshake and result-format slips.
// ----------------------------------------------------------------------------
module mld_checker
    import mld_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [1:0]        o_kind,
    input logic [CHAR_W-1:0] o_char_code
);

    // A stalled result must hold.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_kind) && $stable(o_char_code))
        else $error("result changed while stalled");

    // With the result register empty, the input side can always move.
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with an empty result register");

    a_space_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == KIND_SPACE) |-> o_char_code == SPACE_CHAR)
        else $error("word space without the space code");

    a_end_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == KIND_END) |-> o_char_code == '0)
        else $error("end of message with a nonzero code");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind morse_light_decoder_core mld_checker u_mld_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_kind      (o_kind),
    .o_char_code (o_char_code)
);

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// Morse light decoder testbench
// Drives timestamped light samples and host acknowledges into the decoder,
// predicts every character, word space and end of message, and checks each
// result in order, in several tests while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
    import mld_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 6;

    typedef struct {
        t_kind             kind;
        logic [CHAR_W-1:0] code;
    } t_decoded;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic                i_cfg_index;
    logic [DOT_W-1:0]    i_cfg_data;
    logic                i_in_valid;
    logic                o_in_stall;
    logic                i_op;
    logic [THRESH_W-1:0] i_sample;
    logic [TIME_W-1:0]   i_now_ms;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [1:0]          o_kind;
    logic [CHAR_W-1:0]   o_char_code;

    morse_light_decoder_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (i_op),
        .i_sample    (i_sample),
        .i_now_ms    (i_now_ms),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_kind      (o_kind),
        .o_char_code (o_char_code)
    );

    // Letters and digits in table order; the end marker is not a character.
    string morse_patterns [36] = '{
        ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
        "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
        "..-", "...-", ".--", "-..-", "-.--", "--..", "-----", ".----",
        "..---", "...--", "....-", ".....", "-....", "--...", "---..", "----."
    };
    string morse_letters = "abcdefghijklmnopqrstuvwxyz0123456789";

    // Decoder state as predicted by the testbench.
    logic [THRESH_W-1:0] level_thr;
    logic [DOT_W-1:0]    dot_ms;
    logic                light_on;
    logic [TIME_W-1:0]   pulse_t0;
    logic [TIME_W-1:0]   edge_ms;
    logic [7:0]          sym_bits;
    int                  sym_len;
    logic                space_sent;
    logic                msg_open;

    t_decoded            decoded_fifo [$];
    int                  error_count;
    int                  cycle_count;
    int                  requests_sent;
    logic [TIME_W-1:0]   clock_ms;

    // Sender and receiver pacing.
    int                  burst_left;
    int                  gap_max;
    int                  stall_pct;
    int                  stall_max;
    int                  stall_left;

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver back-pressure: runs of stall of random length.
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
            i_out_stall <= 1'b1;
            stall_left  <= $urandom_range(1, stall_max);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= 10) begin
            $display("%s", msg);
        end
    endtask

    // Outputs only change at the rising edge, so the negative edge sees the
    // values that the next rising edge will accept.
    always @(negedge i_clk) begin : result_check
        t_decoded want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (decoded_fifo.size() == 0) begin
                report_error($sformatf("cycle %0d: unexpected result kind %0d char %h",
                    cycle_count, o_kind, o_char_code));
            end else begin
                want = decoded_fifo.pop_front();
                if (o_kind !== want.kind || o_char_code !== want.code) begin
                    report_error($sformatf(
                        "cycle %0d: expected kind %0d char %h, got kind %0d char %h",
                        cycle_count, want.kind, want.code, o_kind, o_char_code));
                end
            end
        end
    end

    function automatic bit lookup_symbol(input int len, input logic [7:0] bits,
                                         output logic [CHAR_W-1:0] ch);
        string      pat;
        logic [7:0] pbits;
        bit         hit;
        hit = 1'b0;
        ch  = '0;
        if (len <= MAX_ELEMENTS) begin
            for (int i = 0; i < 36; i++) begin
                pat   = morse_patterns[i];
                pbits = '0;
                for (int k = 0; k < pat.len(); k++) begin
                    pbits = {pbits[6:0], pat[k] == "-"};
                end
                if (!hit && pat.len() == len && pbits == bits) begin
                    hit = 1'b1;
                    ch  = CHAR_W'(morse_letters[i]);
                end
            end
        end
        return hit;
    endfunction

    task automatic add_element(input bit dash);
        if (sym_len < MAX_ELEMENTS) begin
            sym_bits = {sym_bits[6:0], dash};
            sym_len++;
        end else begin
            sym_len = MAX_ELEMENTS + 1;
        end
    endtask

    task automatic push_decoded(input t_kind kind, input logic [CHAR_W-1:0] code);
        t_decoded item;
        item.kind = kind;
        item.code = code;
        decoded_fifo.push_back(item);
    endtask

    task automatic predict_request(input t_op op, input logic [THRESH_W-1:0] smp,
                                   input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] span;
        logic [63:0]       span64;
        logic [63:0]       dot64;
        logic [CHAR_W-1:0] ch;
        bit                hit;
        dot64 = 64'(dot_ms);
        if (op == OP_ACK) begin
            msg_open = 1'b0;
        end else if (smp > level_thr) begin
            if (!light_on) begin
                light_on   = 1'b1;
                space_sent = 1'b0;
                pulse_t0   = now;
            end
        end else if (light_on) begin
            span     = now - pulse_t0;
            span64   = 64'(span);
            light_on = 1'b0;
            if (span64 <= dot64) begin
                add_element(1'b0);
            end else if (span64 <= 64'd3 * dot64) begin
                add_element(1'b1);
            end
            edge_ms = now;
        end else begin
            span   = now - edge_ms;
            span64 = 64'(span);
            if (64'd5 * span64 >= 64'd9 * dot64 && sym_len != 0) begin
                hit      = lookup_symbol(sym_len, sym_bits, ch);
                sym_bits = '0;
                sym_len  = 0;
                if (hit) begin
                    msg_open = 1'b1;
                    push_decoded(KIND_CHAR, ch);
                end else if (msg_open) begin
                    push_decoded(KIND_END, '0);
                end
            end else if (64'd2 * span64 >= 64'd9 * dot64 && msg_open && !space_sent) begin
                space_sent = 1'b1;
                edge_ms    = now;
                push_decoded(KIND_SPACE, SPACE_CHAR);
            end
        end
    endtask

    // Sends one request, with random idle gaps between bursts.
    task automatic send_request(input t_op op, input logic [THRESH_W-1:0] smp,
                                input logic [TIME_W-1:0] now);
        int idle;
        bit took;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            idle       = (gap_max != 0) ? $urandom_range(0, gap_max) : 0;
            if (idle != 0) begin
                i_in_valid <= 1'b0;
                repeat (idle) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_sample   <= smp;
        i_now_ms   <= now;
        do begin
            @(negedge i_clk);
            took = !o_in_stall;
            @(posedge i_clk);
        end while (!took);
        predict_request(op, smp, now);
        requests_sent++;
    endtask

    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (decoded_fifo.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input t_cfg_index idx, input logic [DOT_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_THRESHOLD) begin
            level_thr = value[THRESH_W-1:0];
        end else begin
            dot_ms = value;
        end
    endtask

    function automatic logic [THRESH_W-1:0] bright_level();
        if (level_thr == 10'd1023) begin
            return 10'd1023;
        end else begin
            return THRESH_W'($urandom_range(int'(level_thr) + 1, 1023));
        end
    endfunction

    function automatic logic [THRESH_W-1:0] dark_level();
        return THRESH_W'($urandom_range(0, int'(level_thr)));
    endfunction

    task automatic send_dark(input int unsigned gap);
        clock_ms = clock_ms + gap;
        send_request(OP_SAMPLE, dark_level(), clock_ms);
    endtask

    // Light goes on after gap and off after dur; sometimes the sensor reports
    // an extra bright sample in the middle of the pulse.
    task automatic send_pulse(input int unsigned gap, input int unsigned dur);
        logic [TIME_W-1:0] start;
        start = clock_ms + gap;
        send_request(OP_SAMPLE, bright_level(), start);
        if ($urandom_range(4) == 0) begin
            send_request(OP_SAMPLE, bright_level(), start + $urandom_range(0, dur));
        end
        clock_ms = start + dur;
        send_request(OP_SAMPLE, dark_level(), clock_ms);
    endtask

    // One symbol with random timing, mostly a table character, then usually
    // the letter gap and sometimes a word gap.
    task automatic send_random_symbol();
        bit          dashes [$];
        string       pat;
        int unsigned dot, dur, inner, first, short_max, decode_min, space_min;
        int unsigned g1, g2;
        int          pick;
        dot        = dot_ms;
        short_max  = (dot != 0) ? (9 * dot - 1) / 5 : 0;
        decode_min = (9 * dot + 4) / 5;
        space_min  = (9 * dot + 1) / 2;
        pick       = $urandom_range(99);
        if (pick < 80) begin
            pat = (pick < 68) ? morse_patterns[$urandom_range(0, 35)] : ".-.-.";
            for (int k = 0; k < pat.len(); k++) dashes.push_back(pat[k] == "-");
        end else begin
            repeat ($urandom_range(1, 7)) dashes.push_back($urandom_range(0, 1));
        end
        foreach (dashes[k]) begin
            if (!dashes[k]) begin
                dur = ($urandom_range(3) == 0) ? dot : $urandom_range(0, dot);
            end else if (dot == 0) begin
                dur = 0;
            end else if ($urandom_range(3) == 0) begin
                dur = $urandom_range(0, 1) ? dot + 1 : 3 * dot;
            end else begin
                dur = $urandom_range(dot + 1, 3 * dot);
            end
            if ($urandom_range(9) == 0) begin
                dur = 3 * dot + 1 + $urandom_range(0, dot);
            end
            inner = (k == 0) ? $urandom_range(0, dot) : $urandom_range(0, short_max);
            if (k != 0 && $urandom_range(4) == 0) begin
                first = $urandom_range(0, inner);
                send_dark(first);
                inner = inner - first;
            end
            send_pulse(inner, dur);
        end
        // Leaving out the letter gap now and then runs symbols together.
        if ($urandom_range(9) != 0) begin
            g1 = decode_min + (($urandom_range(3) == 0) ? 0 : $urandom_range(0, 2 * dot));
            send_dark(g1);
            if ($urandom_range(9) < 3) begin
                g2 = ((g1 > space_min) ? g1 : space_min)
                     + ($urandom_range(0, 1) ? 0 : $urandom_range(0, dot));
                send_dark(g2 - g1);
            end
        end
    endtask

    task automatic run_random_traffic(input int count, input bit pause_inside);
        int stop_at;
        int pick;
        stop_at = requests_sent + count;
        while (requests_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                send_request(OP_ACK, THRESH_W'($urandom), $urandom);
            end else if (pick < 20) begin
                clock_ms = $urandom;
                send_request(t_op'($urandom_range(0, 1)), THRESH_W'($urandom), clock_ms);
            end else begin
                send_random_symbol();
            end
            if (pause_inside && $urandom_range(19) == 0) begin
                wait_results_drained();
            end
        end
    endtask

    task automatic set_pacing(input int gaps, input int pct, input int longest);
        gap_max   = gaps;
        stall_pct = pct;
        stall_max = longest;
    endtask

    // Exact dot, dash and gap boundaries at reset settings, across the
    // timestamp wrap: "e", then "m" around an overlong pulse, then a word space.
    task automatic test_timing_boundaries();
        wait_results_drained();
        set_pacing(0, 0, 1);
        send_request(OP_ACK, 10'd1023, 32'hFFFF_FFFF);
        clock_ms = 32'hFFFF_FFC0;
        send_request(OP_SAMPLE, 10'd513, clock_ms);
        clock_ms = clock_ms + 100;
        send_request(OP_SAMPLE, 10'd512, clock_ms);
        send_dark(179);
        send_dark(1);
        send_pulse(20, 300);
        send_pulse(100, 301);
        send_pulse(100, 101);
        send_dark(449);
        send_dark(0);
        send_dark(1);
        send_dark(1000);
    endtask

    // The end marker closes an open message; the host then takes it.
    task automatic test_end_marker();
        send_pulse(100, 0);
        send_pulse(179, 299);
        send_pulse(179, 50);
        send_pulse(100, 200);
        send_pulse(100, 1);
        clock_ms = clock_ms + 180;
        send_request(OP_SAMPLE, 10'd0, clock_ms);
        send_request(OP_ACK, 10'd0, 32'h0000_0000);
    endtask

    task automatic test_steady_stream();
        wait_results_drained();
        write_register(CFG_THRESHOLD, DOT_W'($urandom_range(100, 900)));
        write_register(CFG_DOT_LEN, DOT_W'($urandom_range(5, 300)));
        set_pacing(0, 0, 1);
        run_random_traffic(100, 1'b0);
    endtask

    task automatic test_low_extremes();
        wait_results_drained();
        write_register(CFG_THRESHOLD, '0);
        write_register(CFG_DOT_LEN, DOT_W'(1));
        set_pacing(6, 40, 6);
        run_random_traffic(80, 1'b0);
    endtask

    // With a zero dot length only zero-length pulses are dots and every
    // dark sample after an edge passes both gap tests.
    task automatic test_zero_dot();
        wait_results_drained();
        write_register(CFG_THRESHOLD, DOT_W'(300));
        write_register(CFG_DOT_LEN, '0);
        set_pacing(3, 25, 4);
        run_random_traffic(60, 1'b0);
    endtask

    // Light can never count as on at the top threshold.
    task automatic test_threshold_ceiling();
        wait_results_drained();
        write_register(CFG_THRESHOLD, DOT_W'(1023));
        write_register(CFG_DOT_LEN, DOT_W'(100));
        set_pacing(2, 20, 3);
        run_random_traffic(30, 1'b0);
    endtask

    task automatic test_long_dot();
        wait_results_drained();
        write_register(CFG_THRESHOLD, DOT_W'($urandom_range(0, 1022)));
        write_register(CFG_DOT_LEN, 16'hFFFF);
        set_pacing(8, 60, 12);
        run_random_traffic(100, 1'b0);
    endtask

    // Sender now and then holds off until every expected result is out.
    task automatic test_paused_stream();
        wait_results_drained();
        write_register(CFG_THRESHOLD, DOT_W'(THRESH_RESET));
        write_register(CFG_DOT_LEN, DOT_W'($urandom_range(1, 2000)));
        set_pacing(4, 30, 8);
        run_random_traffic(100, 1'b1);
    endtask

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_THRESHOLD;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_op        = OP_SAMPLE;
        i_sample    = '0;
        i_now_ms    = '0;
        i_out_stall = 1'b0;

        level_thr   = THRESH_RESET;
        dot_ms      = DOT_RESET;
        light_on    = 1'b0;
        pulse_t0    = '0;
        edge_ms     = '0;
        sym_bits    = '0;
        sym_len     = 0;
        space_sent  = 1'b0;
        msg_open    = 1'b0;

        error_count   = 0;
        cycle_count   = 0;
        requests_sent = 0;
        clock_ms      = '0;
        burst_left    = 0;
        stall_left    = 0;
        set_pacing(0, 0, 1);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_timing_boundaries();
        test_end_marker();
        test_steady_stream();
        test_low_extremes();
        test_zero_dot();
        test_threshold_ceiling();
        test_long_dot();
        test_paused_stream();

        wait_results_drained();
        if (error_count == 0 && decoded_fifo.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
